[src/radix_conversion_to_ascii_top_macros.svh]
// assertion macros shared by the rtl
// each macro expects clk and arst_n in the enclosing module
`ifndef RADIX_CONVERSION_TO_ASCII_TOP_MACROS_SVH
`define RADIX_CONVERSION_TO_ASCII_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define RCTA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcta assertion failed");

`define RCTA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcta assertion failed");

`else

`define RCTA_ASSERT_IMP(name, ante, cons)

`define RCTA_ASSERT_NXT(name, ante, cons)

`endif

`endif

[src/rcta_pkg.sv]
`timescale 1ns / 1ps

package rcta_pkg;

	localparam int VALUE_W       = 64;
	localparam int RADIX_W       = 8;
	localparam int SYM_W         = 8;
	localparam int DIGIT_W       = 6;
	localparam int IN_TDATA_W    = 72;
	localparam int BITS_PER_STEP = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd36;

	localparam logic [SYM_W-1:0] SYM_ZERO   = 8'h30;
	localparam logic [SYM_W-1:0] SYM_ALPHA  = 8'h37;
	localparam logic [SYM_W-1:0] SYM_NONE   = 8'h00;

	typedef logic [DIGIT_W-1:0] digit_t;

	// digit value to ascii, 0-9 then A-Z
	function automatic logic [SYM_W-1:0] sym_of(input digit_t d);
		logic [SYM_W-1:0] r;
		if (d < 6'd10) begin
			r = SYM_ZERO + {2'b00, d};
		end else if (d < 6'd36) begin
			r = SYM_ALPHA + {2'b00, d};
		end else begin
			r = SYM_NONE;
		end
		return r;
	endfunction

endpackage

[src/rcta_ram.sv]
`timescale 1ns / 1ps

module rcta_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/rcta_div.sv]
`timescale 1ns / 1ps
`include "radix_conversion_to_ascii_top_macros.svh"

module rcta_div
	import rcta_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] dividend,
	input  digit_t             divisor,
	output logic               done,
	output logic [VALUE_W-1:0] quotient,
	output digit_t             remainder
);

	localparam int STEPS = VALUE_W / BITS_PER_STEP;
	localparam int CNT_W = $clog2(STEPS);

	logic [VALUE_W-1:0] quo_q;
	logic [VALUE_W-1:0] quo_nx;
	digit_t             rem_q;
	digit_t             rem_nx;
	digit_t             dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               last_step;

	// restoring division, BITS_PER_STEP quotient bits per cycle while busy
	always_comb begin
		logic [DIGIT_W:0]   t;
		logic [VALUE_W-1:0] q;
		digit_t             r;
		q = quo_q;
		r = rem_q;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t = {r, q[VALUE_W-1]};
			q = {q[VALUE_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
				q[0] = 1'b1;
			end
			r = t[DIGIT_W-1:0];
		end
		quo_nx = q;
		rem_nx = r;
	end

	assign last_step = (cnt_q == CNT_W'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`RCTA_ASSERT_NXT(a_start_busy, start, busy_q)
	`RCTA_ASSERT_IMP(a_start_idle, start, !busy_q)
	`RCTA_ASSERT_IMP(a_rem_range, done_q, rem_q < dvs_q)

endmodule

[src/radix_conversion_to_ascii_top.sv]
// radix conversion to ascii
// input stream s_*: one transaction carries a 64-bit unsigned value and a base.
// output stream m_*: one transaction per digit, most significant digit first,
// ascii 0-9 then A-Z in m_tdata; m_tlast marks the final digit of a value.
// a base outside 2..36 gives a single transaction with m_tuser = 1,
// m_tdata = 0 and m_tlast = 1. a value of zero gives the single digit '0'.
// timing: digits come from a shared divider that retires 4 quotient bits a
// cycle; the digits are kept in a small ram and read back in reverse, each
// through a ram read state and then an output state. a bad base goes from
// idle to a bad state that loads its single transaction into the output
// register. s_tready is low from acceptance until the final digit has been
// loaded into the output register.
// a stalled receiver holds the output register; readout waits for it.
// reset clears all control state; the digit ram needs no clearing.
`timescale 1ns / 1ps
`include "radix_conversion_to_ascii_top_macros.svh"

module radix_conversion_to_ascii_top
	import rcta_pkg::*;
#(
	parameter int MAX_DIGITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // value[63:0], radix[71:64]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [SYM_W-1:0]      m_tdata,   // symbol[7:0]
	output logic                  m_tlast,
	output logic                  m_tuser    // bad_radix
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;
	localparam logic [2:0] ST_BAD  = 3'd4;

	logic [2:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_inc;
	logic [AW-1:0]      rd_idx_q;
	digit_t             radix_q;

	logic [VALUE_W-1:0] in_value;
	logic [RADIX_W-1:0] in_radix;
	logic               in_fire;
	logic               radix_ok;
	logic               more;

	logic               div_start;
	logic [VALUE_W-1:0] div_dividend;
	digit_t             div_divisor;
	logic               div_done;
	logic [VALUE_W-1:0] div_quo;
	digit_t             div_rem;

	logic               ram_we;
	logic               ram_re;
	digit_t             ram_rdata;

	logic               out_free;
	logic               out_load;
	logic               m_tvalid_q;
	logic [SYM_W-1:0]   m_tdata_q;
	logic               m_tlast_q;
	logic               m_tuser_q;

	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_radix = s_tdata[VALUE_W +: RADIX_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign radix_ok = (in_radix >= RADIX_MIN) && (in_radix <= RADIX_MAX);

	assign cnt_inc = cnt_q + 1'b1;
	assign more    = (div_quo != '0) && (cnt_inc < CW'(MAX_DIGITS));

	assign div_start    = (in_fire && radix_ok) || ((state_q == ST_DIV) && div_done && more);
	assign div_dividend = (state_q == ST_IDLE) ? in_value : div_quo;
	assign div_divisor  = (state_q == ST_IDLE) ? in_radix[DIGIT_W-1:0] : radix_q;

	assign ram_we = (state_q == ST_DIV) && div_done;
	assign ram_re = (state_q == ST_RD);

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = ((state_q == ST_OUT) || (state_q == ST_BAD)) && out_free;

	rcta_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	rcta_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (div_rem),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			radix_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q   <= '0;
						radix_q <= in_radix[DIGIT_W-1:0];
						state_q <= radix_ok ? ST_DIV : ST_BAD;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						cnt_q <= cnt_inc;
						if (!more) begin
							rd_idx_q <= cnt_q[AW-1:0];
							state_q  <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= ST_RD;
						end
					end
				end
				ST_BAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= (state_q == ST_BAD) ? SYM_NONE : sym_of(ram_rdata);
			m_tlast_q <= (state_q == ST_BAD) || (rd_idx_q == '0);
			m_tuser_q <= (state_q == ST_BAD);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	`RCTA_ASSERT_NXT(a_busy_after_accept, in_fire, !s_tready)
	`RCTA_ASSERT_IMP(a_bad_single, m_tvalid && m_tuser, m_tlast && (m_tdata == SYM_NONE))
	`RCTA_ASSERT_IMP(a_cnt_range, state_q == ST_DIV, cnt_q < CW'(MAX_DIGITS))

endmodule

[tb/tb_radix_conversion_to_ascii_top.sv]
`timescale 1ns / 1ps

module tb_radix_conversion_to_ascii_top;
	import rcta_pkg::*;

	localparam int DIGIT_CAP      = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 64;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
		logic             bad_radix;
	} digit_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [SYM_W-1:0]      m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	logic                  steady_flow = 1'b0;
	int                    failures = 0;
	int                    quiet_cycles = 0;
	digit_result_t         expected_digits[$];

	radix_conversion_to_ascii_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// queue the digit transactions one conversion must produce
	task automatic predict_digits(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix);
		logic [DIGIT_W-1:0] digit_buf[DIGIT_CAP];
		logic [VALUE_W-1:0] quotient;
		logic [DIGIT_W-1:0] d;
		digit_result_t      res;
		int                 n;
		n = 0;
		if (radix < 8'd2 || radix > 8'd36) begin
			res.symbol = 8'h00;
			res.last = 1'b1;
			res.bad_radix = 1'b1;
			expected_digits.push_back(res);
		end else begin
			quotient = value;
			if (quotient == 64'd0) begin
				digit_buf[0] = 6'd0;
				n = 1;
			end else begin
				while (quotient != 64'd0 && n < DIGIT_CAP) begin
					digit_buf[n] = DIGIT_W'(quotient % {56'd0, radix});
					quotient = quotient / {56'd0, radix};
					n++;
				end
			end
			for (int k = 0; k < n; k++) begin
				d = digit_buf[n - 1 - k];
				if (d < 6'd10) begin
					res.symbol = 8'h30 + {2'b00, d};
				end else if (d < 6'd36) begin
					res.symbol = 8'h41 + {2'b00, d} - 8'd10;
				end else begin
					res.symbol = 8'h00;
				end
				res.last = (k == n - 1);
				res.bad_radix = 1'b0;
				expected_digits.push_back(res);
			end
		end
	endtask

	task automatic send_conversion(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix);
		while (!steady_flow && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {radix, value};
		do @(posedge clk); while (!s_tready);
		predict_digits(value, radix);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_digits.size() != 0);
	endtask

	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		int                 width;
		v = {$urandom, $urandom};
		width = $urandom_range(64);
		if (width < 64) begin
			v = v & ((64'd1 << width) - 64'd1);
		end
		if ($urandom_range(19) == 0) begin
			v = '1;
		end
		return v;
	endfunction

	function automatic logic [RADIX_W-1:0] rand_radix();
		logic [RADIX_W-1:0] r;
		case ($urandom_range(19))
			0: r = 8'd0;
			1: r = 8'd1;
			2: r = 8'($urandom_range(255, 37));
			default: r = 8'($urandom_range(36, 2));
		endcase
		return r;
	endfunction

	task automatic test_extremes();
		send_conversion(64'd0, 8'd2);
		send_conversion(64'd0, 8'd36);
		send_conversion('1, 8'd2);
		send_conversion('1, 8'd10);
		send_conversion('1, 8'd16);
		send_conversion('1, 8'd36);
		send_conversion(64'd1, 8'd2);
		send_conversion(64'd35, 8'd36);
		send_conversion(64'd36, 8'd36);
		send_conversion(64'h8000_0000_0000_0000, 8'd2);
		send_conversion(64'h5555_5555_5555_5555, 8'd3);
		send_conversion(64'hAAAA_AAAA_AAAA_AAAA, 8'd35);
		send_conversion(64'd12345678901234, 8'd7);
	endtask

	task automatic test_bad_radix();
		send_conversion(64'd0, 8'd0);
		send_conversion('1, 8'd1);
		send_conversion(64'd100, 8'd37);
		send_conversion(64'h0123_4567_89AB_CDEF, 8'd128);
		send_conversion('1, 8'd255);
		send_conversion(64'd0, 8'd64);
		send_conversion(64'd9, 8'd10);
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			send_conversion(rand_value(), rand_radix());
		end
	endtask

	task automatic test_drain_pauses(input int count);
		for (int i = 0; i < count; i++) begin
			send_conversion(rand_value(), rand_radix());
			if (i % 8 == 7) begin
				wait_for_drain();
			end
		end
	endtask

	task automatic test_steady_stream(input int count);
		steady_flow <= 1'b1;
		for (int i = 0; i < count; i++) begin
			send_conversion(rand_value(), rand_radix());
		end
		steady_flow <= 1'b0;
	endtask

	always @(posedge clk) begin
		m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 16);
	end

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		digit_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_digits.size() == 0) begin
				$error("unexpected output transaction symbol=%h last=%b bad_radix=%b",
					m_tdata, m_tlast, m_tuser);
				failures++;
			end else begin
				want = expected_digits.pop_front();
				if (m_tdata !== want.symbol) begin
					$error("symbol: expected %h, actual %h", want.symbol, m_tdata);
					failures++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %b, actual %b", want.last, m_tlast);
					failures++;
				end
				if (m_tuser !== want.bad_radix) begin
					$error("bad_radix: expected %b, actual %b", want.bad_radix, m_tuser);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_bad_radix();
		test_random_mix(170);
		test_drain_pauses(80);
		test_steady_stream(60);
		test_random_mix(20);
		s_tvalid <= 1'b0;
		while (expected_digits.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && expected_digits.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
